@@ design/two_level_write_back_cache_defines.svh @@
// assertion macros for the two-level write-back cache
`ifndef TWO_LEVEL_WRITE_BACK_CACHE_DEFINES_SVH
`define TWO_LEVEL_WRITE_BACK_CACHE_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define TLWBC_ASSERT_IMP(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define TLWBC_ASSERT_NXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define TLWBC_ASSERT_IMP(lbl, clk, rstn, a, b)
`define TLWBC_ASSERT_NXT(lbl, clk, rstn, a, b)
`endif
`endif

@@ design/tlwbc_pkg.sv @@
// shared constants and controller/datapath types for the two-level cache
package tlwbc_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int OFF_W       = 4;
    localparam int L1_LINES    = 256;
    localparam int L1_IDX_W    = 8;
    localparam int L2_SETS     = 256;
    localparam int L2_SET_W    = 8;
    localparam int MEM_WORDS   = 262144;
    localparam int WADDR_W     = 18;
    localparam int BLK_W       = WADDR_W - OFF_W;
    localparam int L1_TAG_W    = BLK_W - L1_IDX_W;
    localparam int L2_TAG_W    = BLK_W - L2_SET_W;
    localparam int CFG_W       = 10;
    localparam int CFG_REGS    = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int ACOST_W     = 13;

    // commands
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_INVAL = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_L1_RD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_WR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_RD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_WR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_RD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_WR = 3'd5;

    // block transfer endpoints
    localparam logic [1:0] SEL_L1  = 2'd0;
    localparam logic [1:0] SEL_L2  = 2'd1;
    localparam logic [1:0] SEL_MEM = 2'd2;

    // result kinds
    localparam logic [1:0] RSP_ACCESS = 2'd0;
    localparam logic [1:0] RSP_CLEAR  = 2'd1;
    localparam logic [1:0] RSP_INVAL  = 2'd2;
    localparam logic [1:0] RSP_AERR   = 2'd3;

    typedef struct packed {
        logic                 load;
        logic                 clearing;
        logic                 l1_check;
        logic                 l2op_load;
        logic                 l2op_wr;
        logic                 l2_latch;
        logic                 copy_start;
        logic [1:0]           copy_src;
        logic [1:0]           copy_dst;
        logic                 add_cost;
        logic [CFG_IDX_W-1:0] cost_sel;
        logic                 l2_install;
        logic                 l2_finish;
        logic                 l1_install;
        logic                 l1_word_wr;
        logic                 invalidate;
        logic                 respond;
        logic [1:0]           resp_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       addr_err;
        logic       l1_hit;
        logic       l1_victim_dirty;
        logic       l2_hit;
        logic       l2_victim_dirty;
        logic       op_wr;
        logic       copy_done;
        logic       clear_last;
    } dp_status_t;

endpackage

@@ design/tlwbc_dp.sv @@
// datapath: cache and backing memories, tags, flags, block copy engine, costs
`include "two_level_write_back_cache_defines.svh"
module tlwbc_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [1:0]                           command,
    input  logic [19:0]                          byte_address,
    input  logic [31:0]                          write_word,
    input  logic                                 cfg_write,
    input  logic [tlwbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlwbc_pkg::CFG_W-1:0]          cfg_data,
    input  tlwbc_pkg::ctrl_cmd_t                 cmd,
    output tlwbc_pkg::dp_status_t                status,
    output logic                                 done,
    output logic [31:0]                          read_word,
    output logic [tlwbc_pkg::ACOST_W-1:0]        access_cost,
    output logic [31:0]                          time_total,
    output logic                                 l1_hit,
    output logic                                 l2_hit,
    output logic                                 address_error
);
    localparam int OFF_W    = tlwbc_pkg::OFF_W;
    localparam int BLK_W    = tlwbc_pkg::BLK_W;
    localparam int WADDR_W  = tlwbc_pkg::WADDR_W;
    localparam int L1_IDX_W = tlwbc_pkg::L1_IDX_W;
    localparam int L2_SET_W = tlwbc_pkg::L2_SET_W;
    localparam int L1_TAG_W = tlwbc_pkg::L1_TAG_W;
    localparam int L2_TAG_W = tlwbc_pkg::L2_TAG_W;
    localparam int ACOST_W  = tlwbc_pkg::ACOST_W;
    localparam logic [WADDR_W:0] MEM_LIMIT = (WADDR_W+1)'(tlwbc_pkg::MEM_WORDS);

    // memories
    logic [31:0]         l1_word_mem [tlwbc_pkg::L1_LINES*tlwbc_pkg::BLOCK_WORDS];
    logic [L1_TAG_W-1:0] l1_tag_mem  [tlwbc_pkg::L1_LINES];
    logic [31:0]         l2_word_mem [tlwbc_pkg::L2_SETS*2*tlwbc_pkg::BLOCK_WORDS];
    logic [L2_TAG_W-1:0] l2_tag0_mem [tlwbc_pkg::L2_SETS];
    logic [L2_TAG_W-1:0] l2_tag1_mem [tlwbc_pkg::L2_SETS];
    logic [31:0]         back_mem    [tlwbc_pkg::MEM_WORDS];

    logic [1:0]                          cmd_reg;
    logic [WADDR_W-1:0]                  waddr_reg;
    logic [31:0]                         wdata_reg;
    logic [tlwbc_pkg::CFG_W-1:0]         cfg_reg [tlwbc_pkg::CFG_REGS];
    logic [tlwbc_pkg::L1_LINES-1:0]      l1_valid_reg, l1_dirty_reg;
    logic [tlwbc_pkg::L2_SETS-1:0][1:0]  l2_valid_reg, l2_dirty_reg;
    logic [tlwbc_pkg::L2_SETS-1:0]       lru_reg;
    logic [BLK_W-1:0]                    op_blk_reg;
    logic                                op_wr_reg, way_reg, l1hit_reg, l2hit_reg;
    logic [L2_TAG_W-1:0]                 vtag_reg;
    logic                                rd_act_reg, wr_act_reg, mem_ok_reg;
    logic [OFF_W-1:0]                    rd_off_reg, wr_off_reg;
    logic [1:0]                          src_reg, dst_reg;
    logic [WADDR_W-1:0]                  clr_cnt_reg;
    logic [ACOST_W-1:0]                  cost_reg;
    logic [31:0]                         elapsed_reg;
    logic [31:0]                         l1_q, l2_q, mem_q;
    logic [L1_TAG_W-1:0]                 l1_tag_q;
    logic [L2_TAG_W-1:0]                 tag0_q, tag1_q;

    logic [OFF_W-1:0]    off;
    logic [BLK_W-1:0]    blk;
    logic [L1_IDX_W-1:0] l1_idx;
    logic [L1_TAG_W-1:0] l1_tag;
    logic [L2_SET_W-1:0] op_set;
    logic [L2_TAG_W-1:0] op_tag;
    logic                hit0, hit1, l2_hit_c, way_c, lru_way;
    logic [OFF_W-1:0]    l1_rd_off, l1_wr_off;
    logic                l1_we;
    logic [31:0]         l1_wd, copy_data;
    logic [WADDR_W-1:0]  mem_rd_addr, mem_wr_addr;
    logic                mem_rd_ok, mem_wr_ok, mem_we;
    logic [31:0]         elapsed_next;

    // request fields
    assign off    = waddr_reg[OFF_W-1:0];
    assign blk    = waddr_reg[WADDR_W-1:OFF_W];
    assign l1_idx = blk[L1_IDX_W-1:0];
    assign l1_tag = blk[BLK_W-1:L1_IDX_W];
    assign op_set = op_blk_reg[L2_SET_W-1:0];
    assign op_tag = op_blk_reg[BLK_W-1:L2_SET_W];

    // l2 lookup
    assign hit0     = l2_valid_reg[op_set][0] && (tag0_q == op_tag);
    assign hit1     = l2_valid_reg[op_set][1] && (tag1_q == op_tag);
    assign l2_hit_c = hit0 || hit1;
    assign lru_way  = lru_reg[op_set];
    assign way_c    = hit0 ? 1'b0 : (hit1 ? 1'b1 : lru_way);

    // status to the controller
    always_comb
    begin
        status.cmd             = cmd_reg;
        status.addr_err        = ({1'b0, waddr_reg} >= MEM_LIMIT);
        status.l1_hit          = l1_valid_reg[l1_idx] && (l1_tag_q == l1_tag);
        status.l1_victim_dirty = l1_valid_reg[l1_idx] && l1_dirty_reg[l1_idx];
        status.l2_hit          = l2_hit_c;
        status.l2_victim_dirty = !l2_hit_c && l2_valid_reg[op_set][lru_way]
                                 && l2_dirty_reg[op_set][lru_way];
        status.op_wr           = op_wr_reg;
        status.copy_done       = wr_act_reg && (wr_off_reg == OFF_W'(tlwbc_pkg::BLOCK_WORDS-1));
        status.clear_last      = (clr_cnt_reg == WADDR_W'(tlwbc_pkg::MEM_WORDS-1));
    end

    // copy data source
    always_comb
    begin
        case (src_reg)
            tlwbc_pkg::SEL_L1:  copy_data = l1_q;
            tlwbc_pkg::SEL_L2:  copy_data = l2_q;
            tlwbc_pkg::SEL_MEM: copy_data = mem_ok_reg ? mem_q : 32'd0;
            default:            copy_data = 32'd0;
        endcase
    end

    // l1 word port selection
    assign l1_rd_off = (rd_act_reg && src_reg == tlwbc_pkg::SEL_L1) ? rd_off_reg : off;
    assign l1_wr_off = cmd.l1_word_wr ? off : wr_off_reg;
    assign l1_we     = cmd.l1_word_wr || (wr_act_reg && dst_reg == tlwbc_pkg::SEL_L1);
    assign l1_wd     = cmd.l1_word_wr ? wdata_reg : copy_data;

    // backing memory addresses
    assign mem_rd_addr = {op_blk_reg, rd_off_reg};
    assign mem_wr_addr = {vtag_reg, op_set, wr_off_reg};
    assign mem_rd_ok   = ({1'b0, mem_rd_addr} < MEM_LIMIT);
    assign mem_wr_ok   = ({1'b0, mem_wr_addr} < MEM_LIMIT);
    assign mem_we      = cmd.clearing
                         || (wr_act_reg && dst_reg == tlwbc_pkg::SEL_MEM && mem_wr_ok);

    // l1 memories
    always_ff @(posedge clk)
    begin
        if (l1_we)
            l1_word_mem[{l1_idx, l1_wr_off}] <= l1_wd;
        l1_q <= l1_word_mem[{l1_idx, l1_rd_off}];
        if (cmd.l1_install)
            l1_tag_mem[l1_idx] <= l1_tag;
        l1_tag_q <= l1_tag_mem[l1_idx];
    end

    // l2 memories
    always_ff @(posedge clk)
    begin
        if (wr_act_reg && dst_reg == tlwbc_pkg::SEL_L2)
            l2_word_mem[{op_set, way_reg, wr_off_reg}] <= copy_data;
        l2_q <= l2_word_mem[{op_set, way_reg, rd_off_reg}];
        if (cmd.l2_install && !way_reg)
            l2_tag0_mem[op_set] <= op_tag;
        if (cmd.l2_install && way_reg)
            l2_tag1_mem[op_set] <= op_tag;
        tag0_q <= l2_tag0_mem[op_set];
        tag1_q <= l2_tag1_mem[op_set];
    end

    // backing memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            back_mem[cmd.clearing ? clr_cnt_reg : mem_wr_addr] <=
                cmd.clearing ? 32'd0 : copy_data;
        mem_q <= back_mem[mem_rd_addr];
    end

    // request and operation payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= command;
            waddr_reg <= byte_address[19:2];
            wdata_reg <= write_word;
        end
        if (cmd.l2op_load)
            op_blk_reg <= cmd.l2op_wr ? {l1_tag_q, l1_idx} : blk;
        if (cmd.l2_latch)
        begin
            way_reg  <= way_c;
            vtag_reg <= lru_way ? tag1_q : tag0_q;
        end
        mem_ok_reg <= mem_rd_ok;
        wr_off_reg <= rd_off_reg;
        if (cmd.copy_start)
        begin
            src_reg <= cmd.copy_src;
            dst_reg <= cmd.copy_dst;
        end
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0]   <= 10'd1;
            cfg_reg[1]   <= 10'd1;
            cfg_reg[2]   <= 10'd10;
            cfg_reg[3]   <= 10'd10;
            cfg_reg[4]   <= 10'd100;
            cfg_reg[5]   <= 10'd50;
            l1_valid_reg <= '0;
            l1_dirty_reg <= '0;
            l2_valid_reg <= '0;
            l2_dirty_reg <= '0;
            lru_reg      <= '0;
            op_wr_reg    <= 1'b0;
            l1hit_reg    <= 1'b0;
            l2hit_reg    <= 1'b0;
            rd_act_reg   <= 1'b0;
            rd_off_reg   <= '0;
            wr_act_reg   <= 1'b0;
            clr_cnt_reg  <= '0;
            cost_reg     <= '0;
            elapsed_reg  <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_write && cfg_index < 3'(tlwbc_pkg::CFG_REGS))
                cfg_reg[cfg_index] <= cfg_data;
            if (cmd.clearing)
                clr_cnt_reg <= clr_cnt_reg + WADDR_W'(1);
            if (cmd.l2op_load)
                op_wr_reg <= cmd.l2op_wr;
            if (cmd.l1_check)
                l1hit_reg <= status.l1_hit;
            if (cmd.l2_latch)
                l2hit_reg <= l2_hit_c;
            // copy engine: read a word a cycle, write it the cycle after
            wr_act_reg <= rd_act_reg;
            if (cmd.copy_start)
            begin
                rd_act_reg <= 1'b1;
                rd_off_reg <= '0;
            end
            else if (rd_act_reg)
            begin
                rd_off_reg <= rd_off_reg + OFF_W'(1);
                if (rd_off_reg == OFF_W'(tlwbc_pkg::BLOCK_WORDS-1))
                    rd_act_reg <= 1'b0;
            end
            // costs
            if (cmd.load)
                cost_reg <= '0;
            else if (cmd.add_cost)
                cost_reg <= cost_reg + ACOST_W'(cfg_reg[cmd.cost_sel]);
            // tag state
            if (cmd.l2_install)
            begin
                l2_valid_reg[op_set][way_reg] <= 1'b1;
                l2_dirty_reg[op_set][way_reg] <= 1'b0;
            end
            if (cmd.l2_finish)
            begin
                lru_reg[op_set] <= !way_reg;
                if (op_wr_reg)
                    l2_dirty_reg[op_set][way_reg] <= 1'b1;
            end
            if (cmd.l1_install)
            begin
                l1_valid_reg[l1_idx] <= 1'b1;
                l1_dirty_reg[l1_idx] <= 1'b0;
            end
            if (cmd.l1_word_wr)
                l1_dirty_reg[l1_idx] <= 1'b1;
            if (cmd.invalidate)
            begin
                l1_valid_reg <= '0;
                l1_dirty_reg <= '0;
                l2_valid_reg <= '0;
                l2_dirty_reg <= '0;
                lru_reg      <= '0;
            end
            if (cmd.respond)
                elapsed_reg <= elapsed_next;
        end
    end

    localparam logic [1:0] RSP_ACCESS_C = tlwbc_pkg::RSP_ACCESS;
    localparam logic [1:0] RSP_CLEAR_C  = tlwbc_pkg::RSP_CLEAR;

    // running total after this result
    always_comb
    begin
        case (cmd.resp_kind)
            RSP_ACCESS_C: elapsed_next = elapsed_reg + 32'(cost_reg);
            RSP_CLEAR_C:  elapsed_next = 32'd0;
            default:      elapsed_next = elapsed_reg;
        endcase
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= cmd.respond;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            time_total    <= elapsed_next;
            read_word     <= 32'd0;
            access_cost   <= '0;
            l1_hit        <= 1'b0;
            l2_hit        <= 1'b0;
            address_error <= (cmd.resp_kind == tlwbc_pkg::RSP_AERR);
            if (cmd.resp_kind == tlwbc_pkg::RSP_ACCESS)
            begin
                read_word   <= (cmd_reg == tlwbc_pkg::CMD_READ) ? l1_q : 32'd0;
                access_cost <= cost_reg;
                l1_hit      <= l1hit_reg;
                l2_hit      <= !l1hit_reg && l2hit_reg;
            end
        end
    end

    // a new block copy never starts over one still reading
    `TLWBC_ASSERT_IMP(a_copy_idle, clk, rst_n, cmd.copy_start, !rd_act_reg)
    // the word access never collides with a fill write
    `TLWBC_ASSERT_IMP(a_word_no_fill, clk, rst_n, cmd.l1_word_wr, !wr_act_reg)
    // an l2 line is installed only as its fill completes
    `TLWBC_ASSERT_IMP(a_install_on_fill, clk, rst_n, cmd.l2_install, status.copy_done)
endmodule

@@ design/tlwbc_ctrl.sv @@
// controller: sequences lookups, write-backs, fills and results
`include "two_level_write_back_cache_defines.svh"
module tlwbc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  tlwbc_pkg::dp_status_t status,
    output tlwbc_pkg::ctrl_cmd_t  cmd
);
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DEC     = 4'd2;
    localparam logic [3:0] S_L1_CMP  = 4'd3;
    localparam logic [3:0] S_L2_WAIT = 4'd4;
    localparam logic [3:0] S_L2_CMP  = 4'd5;
    localparam logic [3:0] S_MEM_WB  = 4'd6;
    localparam logic [3:0] S_MEM_RD  = 4'd7;
    localparam logic [3:0] S_XFER    = 4'd8;
    localparam logic [3:0] S_ACC     = 4'd9;
    localparam logic [3:0] S_RESP    = 4'd10;

    logic [3:0] state_reg, state_next;

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clearing = 1'b1;
                if (status.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (status.cmd == tlwbc_pkg::CMD_CLEAR)
                begin
                    cmd.respond   = 1'b1;
                    cmd.resp_kind = tlwbc_pkg::RSP_CLEAR;
                    state_next    = S_IDLE;
                end
                else if (status.cmd == tlwbc_pkg::CMD_INVAL)
                begin
                    cmd.invalidate = 1'b1;
                    cmd.respond    = 1'b1;
                    cmd.resp_kind  = tlwbc_pkg::RSP_INVAL;
                    state_next     = S_IDLE;
                end
                else if (status.addr_err)
                begin
                    cmd.respond   = 1'b1;
                    cmd.resp_kind = tlwbc_pkg::RSP_AERR;
                    state_next    = S_IDLE;
                end
                else
                    state_next = S_L1_CMP;
            end
            S_L1_CMP:
            begin
                cmd.l1_check = 1'b1;
                if (status.l1_hit)
                    state_next = S_ACC;
                else
                begin
                    cmd.l2op_load = 1'b1;
                    cmd.l2op_wr   = status.l1_victim_dirty;
                    state_next    = S_L2_WAIT;
                end
            end
            S_L2_WAIT:
                state_next = S_L2_CMP;
            S_L2_CMP:
            begin
                cmd.l2_latch   = 1'b1;
                cmd.copy_start = 1'b1;
                if (status.l2_hit)
                begin
                    cmd.copy_src = status.op_wr ? tlwbc_pkg::SEL_L1 : tlwbc_pkg::SEL_L2;
                    cmd.copy_dst = status.op_wr ? tlwbc_pkg::SEL_L2 : tlwbc_pkg::SEL_L1;
                    state_next   = S_XFER;
                end
                else if (status.l2_victim_dirty)
                begin
                    cmd.copy_src = tlwbc_pkg::SEL_L2;
                    cmd.copy_dst = tlwbc_pkg::SEL_MEM;
                    state_next   = S_MEM_WB;
                end
                else
                begin
                    cmd.copy_src = tlwbc_pkg::SEL_MEM;
                    cmd.copy_dst = tlwbc_pkg::SEL_L2;
                    state_next   = S_MEM_RD;
                end
            end
            S_MEM_WB:
            begin
                if (status.copy_done)
                begin
                    cmd.add_cost   = 1'b1;
                    cmd.cost_sel   = tlwbc_pkg::CFG_MEM_WR;
                    cmd.copy_start = 1'b1;
                    cmd.copy_src   = tlwbc_pkg::SEL_MEM;
                    cmd.copy_dst   = tlwbc_pkg::SEL_L2;
                    state_next     = S_MEM_RD;
                end
            end
            S_MEM_RD:
            begin
                if (status.copy_done)
                begin
                    cmd.add_cost   = 1'b1;
                    cmd.cost_sel   = tlwbc_pkg::CFG_MEM_RD;
                    cmd.l2_install = 1'b1;
                    cmd.copy_start = 1'b1;
                    cmd.copy_src   = status.op_wr ? tlwbc_pkg::SEL_L1 : tlwbc_pkg::SEL_L2;
                    cmd.copy_dst   = status.op_wr ? tlwbc_pkg::SEL_L2 : tlwbc_pkg::SEL_L1;
                    state_next     = S_XFER;
                end
            end
            S_XFER:
            begin
                if (status.copy_done)
                begin
                    cmd.add_cost  = 1'b1;
                    cmd.cost_sel  = status.op_wr ? tlwbc_pkg::CFG_L2_WR : tlwbc_pkg::CFG_L2_RD;
                    cmd.l2_finish = 1'b1;
                    if (status.op_wr)
                    begin
                        // victim written back, now fetch the wanted block
                        cmd.l2op_load = 1'b1;
                        state_next    = S_L2_WAIT;
                    end
                    else
                    begin
                        cmd.l1_install = 1'b1;
                        state_next     = S_ACC;
                    end
                end
            end
            S_ACC:
            begin
                cmd.add_cost = 1'b1;
                if (status.cmd == tlwbc_pkg::CMD_WRITE)
                begin
                    cmd.cost_sel   = tlwbc_pkg::CFG_L1_WR;
                    cmd.l1_word_wr = 1'b1;
                end
                else
                    cmd.cost_sel = tlwbc_pkg::CFG_L1_RD;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                cmd.respond   = 1'b1;
                cmd.resp_kind = tlwbc_pkg::RSP_ACCESS;
                state_next    = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // an accepted command always leaves idle
    `TLWBC_ASSERT_NXT(a_accept_busy, clk, rst_n, start && state_reg == S_IDLE,
                      state_reg == S_DEC)
    // every result returns the controller to idle
    `TLWBC_ASSERT_NXT(a_resp_idle, clk, rst_n, cmd.respond, state_reg == S_IDLE)
    // no result while the backing memory is being cleared
    `TLWBC_ASSERT_IMP(a_no_resp_clear, clk, rst_n, state_reg == S_CLEAR, !cmd.respond)
endmodule

@@ design/two_level_write_back_cache.sv @@
// Two-level write-back cache: direct-mapped L1 (256 lines of 16 words), two-way L2
// (256 sets, one LRU bit each) and a 256K-word backing memory. After reset the block
// clears the backing memory one word a cycle, with busy high; config
// writes are taken during that time. A command is taken when start is high and busy
// low; its result appears on the result ports for one cycle with done high and cannot
// be stalled. Clear-time, invalidate and out-of-range commands are answered from the
// decode state, an L1 hit after tag compare and word access. Every miss moves blocks
// word by word between the memories, and every L2 operation opens with an L2 tag lookup;
// an L1 miss is shortest on an L2 hit, longest with dirty victims at both levels.
module two_level_write_back_cache (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           command,
    input  logic [19:0]                          byte_address,
    input  logic [31:0]                          write_word,
    input  logic                                 cfg_write,
    input  logic [tlwbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlwbc_pkg::CFG_W-1:0]          cfg_data,
    output logic                                 done,
    output logic [31:0]                          read_word,
    output logic [tlwbc_pkg::ACOST_W-1:0]        access_cost,
    output logic [31:0]                          time_total,
    output logic                                 l1_hit,
    output logic                                 l2_hit,
    output logic                                 address_error
);
    tlwbc_pkg::ctrl_cmd_t  cmd;
    tlwbc_pkg::dp_status_t status;

    // sequencer
    tlwbc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // storage and arithmetic
    tlwbc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .command       (command),
        .byte_address  (byte_address),
        .write_word    (write_word),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .done          (done),
        .read_word     (read_word),
        .access_cost   (access_cost),
        .time_total    (time_total),
        .l1_hit        (l1_hit),
        .l2_hit        (l2_hit),
        .address_error (address_error)
    );
endmodule
